@@ hw/rtl/string_to_integer_parser_assert.svh @@
// Assertion macros for the string parser checker
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

// Property checked outside reset
`define STIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked while reset is held
`define STIP_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`endif

@@ hw/rtl/stip_pkg.sv @@
// Types, constants and helpers for the string to integer parser
`timescale 1ns / 1ps

package stip_pkg;

  localparam int unsigned VAL_W      = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CONS_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned DIGIT_W    = 7;

  localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
  localparam logic               SIGNED_RST = 1'b1;
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;

  localparam logic [CONS_W-1:0]  CONS_MAX  = 8'hFF;
  localparam logic [DIGIT_W-1:0] NO_DIGIT  = 7'd99;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX  = 2'd0,
    CFG_SIGNED = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NODIG   = 2'd1,
    ST_BADBASE = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    PH_WS      = 8'b0000_0001,
    PH_SIGN    = 8'b0000_0010,
    PH_ZERO    = 8'b0000_0100,
    PH_XPFX    = 8'b0000_1000,
    PH_DIGITS  = 8'b0001_0000,
    PH_DONE    = 8'b0010_0000,
    PH_NONE    = 8'b0100_0000,
    PH_BADBASE = 8'b1000_0000
  } phase_e;

  // End-of-string record handed from the parser to the output formatter
  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  acc;
    logic              neg;
    logic              ovf;
    logic              sgn;
    logic [CONS_W-1:0] consumed;
  } fin_t;

  // Digit value of a character in any base up to 36, NO_DIGIT otherwise
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA + LETTER_OFS);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA + LETTER_OFS);
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/stip_if.sv @@
// Channel interfaces of the string to integer parser
`timescale 1ns / 1ps

interface stip_in_if;
  logic                          valid;
  logic                          ready;
  logic [stip_pkg::CHAR_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface stip_out_if;
  logic                          valid;
  logic                          ready;
  logic [stip_pkg::VAL_W-1:0]    value;
  logic [stip_pkg::CONS_W-1:0]   consumed;
  logic                          overflowed;
  logic [1:0]                    status;

  modport source (output valid, value, consumed, overflowed, status, input ready);
  modport sink   (input valid, value, consumed, overflowed, status, output ready);
endinterface

interface stip_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [stip_pkg::CFG_IDX_W-1:0]  index;
  logic [stip_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/stip_parse.sv @@
// Per-character parse state and digit accumulation
`timescale 1ns / 1ps

module stip_parse #(
  parameter int unsigned MAX_STRING_LEN = 255,
  parameter int unsigned VALUE_WIDTH    = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic [stip_pkg::CHAR_W-1:0]    char_i,
  input  logic                           last_i,
  input  logic [stip_pkg::RADIX_W-1:0]   radix_i,
  output stip_pkg::fin_t                 fin_o
);

  localparam int unsigned CntW  = $clog2(MAX_STRING_LEN + 1);
  localparam int unsigned ExtW  = CntW + stip_pkg::CONS_W;
  localparam int unsigned ProdW = VALUE_WIDTH + stip_pkg::RADIX_W;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_STRING_LEN);

  stip_pkg::phase_e                 phase_q, phase_c, phase_n;
  logic [VALUE_WIDTH-1:0]           acc_q, acc_n;
  logic                             neg_q, neg_n;
  logic                             ovf_q, ovf_n;
  logic [CntW-1:0]                  cnt_q, cnt_n;
  logic [CntW-1:0]                  dend_q, dend_n;
  logic [stip_pkg::RADIX_W-1:0]     base_q, base_c, base_n;
  logic [stip_pkg::DIGIT_W-1:0]     dig, take_d;
  logic                             take, begin_num, is_ws;
  logic [ProdW-1:0]                 prod;
  logic [ExtW-1:0]                  dend_ext;

  assign dig   = stip_pkg::digit_of(char_i);
  assign is_ws = (char_i == stip_pkg::CH_SPACE) ||
                 (char_i >= stip_pkg::CH_TAB && char_i <= stip_pkg::CH_CR);

  always_comb begin
    // first character of a string latches the base
    if (cnt_q == '0) begin
      base_c  = radix_i;
      phase_c = (radix_i == stip_pkg::BASE_ONE || radix_i > stip_pkg::BASE_MAX) ?
                stip_pkg::PH_BADBASE : stip_pkg::PH_WS;
    end else begin
      base_c  = base_q;
      phase_c = phase_q;
    end
    base_n    = base_c;
    phase_n   = phase_c;
    neg_n     = neg_q;
    take      = 1'b0;
    take_d    = dig;
    begin_num = 1'b0;
    cnt_n     = (cnt_q < MaxCnt) ? cnt_q + CntW'(1) : cnt_q;

    unique case (phase_c)
      stip_pkg::PH_WS: begin
        if (is_ws) begin
          phase_n = stip_pkg::PH_WS;
        end else if (char_i == stip_pkg::CH_MINUS) begin
          neg_n   = 1'b1;
          phase_n = stip_pkg::PH_SIGN;
        end else if (char_i == stip_pkg::CH_PLUS) begin
          phase_n = stip_pkg::PH_SIGN;
        end else begin
          begin_num = 1'b1;
        end
      end
      stip_pkg::PH_SIGN: begin
        begin_num = 1'b1;
      end
      stip_pkg::PH_ZERO: begin
        if (char_i == stip_pkg::CH_LX || char_i == stip_pkg::CH_UX) begin
          base_n  = stip_pkg::BASE_HEX;
          phase_n = stip_pkg::PH_XPFX;
        end else if (dig < {1'b0, base_c}) begin
          take    = 1'b1;
          phase_n = stip_pkg::PH_DIGITS;
        end else begin
          phase_n = stip_pkg::PH_DONE;
        end
      end
      stip_pkg::PH_XPFX, stip_pkg::PH_DIGITS: begin
        if (dig < {1'b0, base_c}) begin
          take    = 1'b1;
          phase_n = stip_pkg::PH_DIGITS;
        end else begin
          phase_n = stip_pkg::PH_DONE;
        end
      end
      stip_pkg::PH_DONE, stip_pkg::PH_NONE, stip_pkg::PH_BADBASE: begin
        phase_n = phase_c;
      end
    endcase

    // a leading zero under auto or hex base counts as a digit
    if (begin_num) begin
      if (char_i == stip_pkg::CH_ZERO &&
          (base_c == stip_pkg::BASE_AUTO || base_c == stip_pkg::BASE_HEX)) begin
        base_n  = (base_c == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT : base_c;
        take    = 1'b1;
        take_d  = '0;
        phase_n = stip_pkg::PH_ZERO;
      end else begin
        base_n = (base_c == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : base_c;
        if (dig < {1'b0, base_n}) begin
          take    = 1'b1;
          phase_n = stip_pkg::PH_DIGITS;
        end else begin
          phase_n = stip_pkg::PH_NONE;
        end
      end
    end
  end

  // one multiply-add by the base; the top bits flag a value past the width
  assign prod = ProdW'(acc_q) * ProdW'(base_n) + ProdW'(take_d);

  always_comb begin
    acc_n  = acc_q;
    ovf_n  = ovf_q;
    dend_n = dend_q;
    if (take) begin
      if (!ovf_q) begin
        if (prod[ProdW-1:VALUE_WIDTH] != '0) begin
          ovf_n = 1'b1;
        end else begin
          acc_n = prod[VALUE_WIDTH-1:0];
        end
      end
      dend_n = cnt_n;
    end
  end

  assign dend_ext = ExtW'(dend_n);

  always_comb begin
    fin_o = '0;
    if (phase_n == stip_pkg::PH_BADBASE) begin
      fin_o.status = stip_pkg::ST_BADBASE;
    end else if (phase_n == stip_pkg::PH_WS || phase_n == stip_pkg::PH_SIGN ||
                 phase_n == stip_pkg::PH_NONE) begin
      fin_o.status = stip_pkg::ST_NODIG;
    end else begin
      fin_o.status = stip_pkg::ST_OK;
    end
    fin_o.acc      = stip_pkg::VAL_W'(acc_n);
    fin_o.neg      = neg_n;
    fin_o.ovf      = ovf_n;
    fin_o.consumed = (dend_ext > ExtW'(stip_pkg::CONS_MAX)) ?
                     stip_pkg::CONS_MAX : dend_ext[stip_pkg::CONS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stip_pkg::PH_WS;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      dend_q  <= '0;
      base_q  <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= stip_pkg::PH_WS;
        acc_q   <= '0;
        neg_q   <= 1'b0;
        ovf_q   <= 1'b0;
        cnt_q   <= '0;
        dend_q  <= '0;
        base_q  <= '0;
      end else begin
        phase_q <= phase_n;
        acc_q   <= acc_n;
        neg_q   <= neg_n;
        ovf_q   <= ovf_n;
        cnt_q   <= cnt_n;
        dend_q  <= dend_n;
        base_q  <= base_n;
      end
    end
  end

endmodule

@@ hw/rtl/stip_format.sv @@
// Sign handling, saturation and status masking of a finished string
`timescale 1ns / 1ps

module stip_format #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  stip_pkg::fin_t                 fin_i,
  output logic [stip_pkg::VAL_W-1:0]     value_o,
  output logic [stip_pkg::CONS_W-1:0]    consumed_o,
  output logic                           overflowed_o,
  output stip_pkg::status_e              status_o
);

  localparam logic [VALUE_WIDTH-1:0] SMax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [VALUE_WIDTH-1:0] SMin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] UMax = {VALUE_WIDTH{1'b1}};

  logic [VALUE_WIDTH-1:0] acc, negated, lim, v;
  logic                   ov;

  assign acc     = fin_i.acc[VALUE_WIDTH-1:0];
  assign negated = '0 - acc;
  assign lim     = fin_i.neg ? SMin : SMax;

  always_comb begin
    if (fin_i.sgn) begin
      ov = fin_i.ovf || (acc > lim);
      v  = ov ? (fin_i.neg ? SMin : SMax) : (fin_i.neg ? negated : acc);
    end else begin
      ov = fin_i.ovf;
      v  = ov ? UMax : (fin_i.neg ? negated : acc);
    end
    status_o = fin_i.status;
    if (fin_i.status == stip_pkg::ST_OK) begin
      value_o      = stip_pkg::VAL_W'(v);
      consumed_o   = fin_i.consumed;
      overflowed_o = ov;
    end else begin
      value_o      = '0;
      consumed_o   = '0;
      overflowed_o = 1'b0;
    end
  end

endmodule

@@ hw/rtl/string_to_integer_parser.sv @@
// String to integer parser: strtol / strtoul over a character stream
//
// in_ch_i carries one character per request; last_char marks the end of a
// string. Each string gives exactly one request on out_ch_o with the
// value, the characters consumed, an overflow flag and a status code.
// cfg_ch_i writes radix (index 0) and signed_mode (index 1); it is always
// ready and should only be used between strings.
// Throughput: one character per cycle, strings back to back, as long as
// each end of string finds room downstream. The path per character is
// one multiply-add of the accumulator by the base. A string's result
// passes the input register, parse stage and output register in turn.
// Reset clears the parse state and all stages; radix returns to 10 and
// signed_mode to 1. No clearing pass is needed.
// When the receiver stalls the result holds in the output register; one
// more finished string waits in the middle stage, and characters keep
// flowing until a further end of string has nowhere to go.
`timescale 1ns / 1ps

module string_to_integer_parser #(
  parameter int unsigned MAX_STRING_LEN = 255,
  parameter int unsigned VALUE_WIDTH    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stip_in_if.sink     in_ch_i,
  stip_out_if.source  out_ch_o,
  stip_cfg_if.sink    cfg_ch_i
);

  logic [stip_pkg::RADIX_W-1:0] radix_q;
  logic                         signed_q;

  logic                         v1_q, last_q;
  logic [stip_pkg::CHAR_W-1:0]  char_q;
  logic                         v2_q;
  stip_pkg::fin_t               fin_c, fin_d, fin_q;
  logic                         v3_q;
  logic [stip_pkg::VAL_W-1:0]   value_d, value_q;
  logic [stip_pkg::CONS_W-1:0]  cons_d, cons_q;
  logic                         ovf_d, ovf_q;
  stip_pkg::status_e            status_d, status_q;

  logic en3, en2, s1_go, in_ready;

  // configuration registers
  assign cfg_ch_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= stip_pkg::RADIX_RST;
      signed_q <= stip_pkg::SIGNED_RST;
    end else if (cfg_ch_i.valid) begin
      unique case (cfg_ch_i.index)
        stip_pkg::CFG_RADIX:  radix_q  <= cfg_ch_i.data[stip_pkg::RADIX_W-1:0];
        stip_pkg::CFG_SIGNED: signed_q <= cfg_ch_i.data[0];
        default: ;
      endcase
    end
  end

  // stage flow: a non-final character needs no room downstream
  assign en3      = !v3_q || out_ch_o.ready;
  assign en2      = !v2_q || en3;
  assign s1_go    = v1_q && (!last_q || en2);
  assign in_ready = !v1_q || s1_go;
  assign in_ch_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready) v1_q <= in_ch_i.valid;
      if (en2)      v2_q <= s1_go && last_q;
      if (en3)      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch_i.valid) begin
      char_q <= in_ch_i.char_code;
      last_q <= in_ch_i.last_char;
    end
    if (s1_go && last_q) begin
      fin_q <= fin_d;
    end
    if (en3 && v2_q) begin
      value_q  <= value_d;
      cons_q   <= cons_d;
      ovf_q    <= ovf_d;
      status_q <= status_d;
    end
  end

  stip_parse #(
    .MAX_STRING_LEN (MAX_STRING_LEN),
    .VALUE_WIDTH    (VALUE_WIDTH)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_go),
    .char_i  (char_q),
    .last_i  (last_q),
    .radix_i (radix_q),
    .fin_o   (fin_c)
  );

  // signedness is taken at the end of the string
  always_comb begin
    fin_d     = fin_c;
    fin_d.sgn = signed_q;
  end

  stip_format #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_format (
    .fin_i        (fin_q),
    .value_o      (value_d),
    .consumed_o   (cons_d),
    .overflowed_o (ovf_d),
    .status_o     (status_d)
  );

  assign out_ch_o.valid      = v3_q;
  assign out_ch_o.value      = value_q;
  assign out_ch_o.consumed   = cons_q;
  assign out_ch_o.overflowed = ovf_q;
  assign out_ch_o.status     = status_q;

endmodule

@@ hw/rtl/stip_checker.sv @@
// Port-level checks on the string to integer parser
`timescale 1ns / 1ps
`include "string_to_integer_parser_assert.svh"

module stip_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [stip_pkg::VAL_W-1:0]    value_i,
  input logic [stip_pkg::CONS_W-1:0]   consumed_i,
  input logic                          overflowed_i,
  input logic [1:0]                    status_i
);

  // no result shows while reset is held
  `STIP_ASSERT_IN_RST(a_no_out_in_reset, clk_i, rst_ni, !out_valid_i, "result valid in reset")

  // a failed parse carries no number
  `STIP_ASSERT(a_fail_zeroed, clk_i, rst_ni, out_valid_i && status_i != stip_pkg::ST_OK |-> value_i == '0 && consumed_i == '0 && !overflowed_i, "failed parse with payload")

  // saturation only on a conversion
  `STIP_ASSERT(a_ovf_only_ok, clk_i, rst_ni, out_valid_i && overflowed_i |-> status_i == stip_pkg::ST_OK, "overflow without conversion")

  // a conversion always covers at least one digit
  `STIP_ASSERT(a_ok_consumes, clk_i, rst_ni, out_valid_i && status_i == stip_pkg::ST_OK |-> consumed_i != '0, "conversion consumed nothing")

  // stalled result holds
  `STIP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_i) && $stable(status_i), "stalled result changed")

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .value_i      (out_ch_o.value),
  .consumed_i   (out_ch_o.consumed),
  .overflowed_i (out_ch_o.overflowed),
  .status_i     (out_ch_o.status)
);

@@ dv/tb_string_to_integer_parser.sv @@
// Self-checking testbench for the streaming string to integer parser
`timescale 1ns / 1ps

module tb_string_to_integer_parser;
  import stip_pkg::*;

  localparam int unsigned MAX_LEN      = 255;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned N_PHASES     = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_e;

  typedef struct {
    logic [VAL_W-1:0]  value;
    logic [CONS_W-1:0] consumed;
    logic              overflowed;
    status_e           status;
  } parse_result_t;

  // Tracks the parser state per character and holds the results still due
  class strtol_scoreboard;
    logic [RADIX_W-1:0] radix_q;
    logic               signed_q;
    phase_e             ph;
    logic [VAL_W-1:0]   acc;
    bit                 neg;
    bit                 sat;
    int unsigned        n_chars;
    int unsigned        end_pos;
    int unsigned        base;
    parse_result_t      expected_results[$];
    int unsigned        mismatches;
    int unsigned        strings_seen;
    int unsigned        n_ok;
    int unsigned        n_sat;
    int unsigned        n_nodig;
    int unsigned        n_badbase;
    int unsigned        widest;

    function new();
      radix_q      = RADIX_RST;
      signed_q     = SIGNED_RST;
      mismatches   = 0;
      strings_seen = 0;
      n_ok         = 0;
      n_sat        = 0;
      n_nodig      = 0;
      n_badbase    = 0;
      widest       = 0;
      clear();
    endfunction

    function void clear();
      ph      = PH_WS;
      acc     = '0;
      neg     = 1'b0;
      sat     = 1'b0;
      n_chars = 0;
      end_pos = 0;
      base    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RADIX:  radix_q = data[RADIX_W-1:0];
        CFG_SIGNED: signed_q = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned char_value(logic [CHAR_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      if (c >= CH_UA && c <= CH_UZ) return c - CH_UA + LETTER_OFS;
      if (c >= CH_LA && c <= CH_LZ) return c - CH_LA + LETTER_OFS;
      return NO_DIGIT;
    endfunction

    function void add_digit(int unsigned d);
      logic [VAL_W-1:0] b;
      logic [VAL_W-1:0] dv;
      b  = (base < 2) ? 2 : base;
      dv = d;
      // once saturated the accumulator is frozen, only the end position moves
      if (!sat) begin
        if (acc > ({VAL_W{1'b1}} - dv) / b) sat = 1'b1;
        else acc = acc * b + dv;
      end
      end_pos = n_chars;
    endfunction

    function void start_number(logic [CHAR_W-1:0] c);
      int unsigned d;
      if (c == CH_ZERO && (base == BASE_AUTO || base == BASE_HEX)) begin
        if (base == BASE_AUTO) base = BASE_OCT;
        add_digit(0);
        ph = PH_ZERO;
      end else begin
        if (base == BASE_AUTO) base = BASE_DEC;
        d = char_value(c);
        if (d < base) begin
          add_digit(d);
          ph = PH_DIGITS;
        end else begin
          ph = PH_NONE;
        end
      end
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic lst);
      int unsigned      d;
      parse_result_t    r;
      logic [VAL_W-1:0] smax;
      logic [VAL_W-1:0] lim;
      d = char_value(c);
      if (n_chars == 0) begin
        clear();
        base = radix_q;
        if (base == BASE_ONE || base > BASE_MAX) ph = PH_BADBASE;
      end
      if (n_chars < MAX_LEN) n_chars++;
      case (ph)
        PH_WS: begin
          if (c == CH_MINUS) begin
            neg = 1'b1;
            ph  = PH_SIGN;
          end else if (c == CH_PLUS) begin
            ph = PH_SIGN;
          end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            start_number(c);
          end
        end
        PH_SIGN: start_number(c);
        PH_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            base = BASE_HEX;
            ph   = PH_XPFX;
          end else if (d < base) begin
            add_digit(d);
            ph = PH_DIGITS;
          end else begin
            ph = PH_DONE;
          end
        end
        PH_XPFX, PH_DIGITS: begin
          if (d < base) begin
            add_digit(d);
            ph = PH_DIGITS;
          end else begin
            ph = PH_DONE;
          end
        end
        default: ;
      endcase
      if (!lst) return;

      smax         = {1'b0, {(VAL_W-1){1'b1}}};
      r.value      = '0;
      r.consumed   = '0;
      r.overflowed = 1'b0;
      if (ph == PH_BADBASE) begin
        r.status = ST_BADBASE;
        n_badbase++;
      end else if (ph == PH_WS || ph == PH_SIGN || ph == PH_NONE) begin
        r.status = ST_NODIG;
        n_nodig++;
      end else begin
        r.status   = ST_OK;
        r.consumed = (end_pos > CONS_MAX) ? CONS_MAX : CONS_W'(end_pos);
        if (signed_q) begin
          lim = neg ? smax + 1 : smax;
          if (sat || acc > lim) begin
            r.overflowed = 1'b1;
            r.value      = neg ? smax + 1 : smax;
          end else begin
            r.value = neg ? -acc : acc;
          end
        end else if (sat) begin
          r.overflowed = 1'b1;
          r.value      = {VAL_W{1'b1}};
        end else begin
          r.value = neg ? -acc : acc;
        end
        n_ok++;
        if (r.overflowed) n_sat++;
        if (r.consumed > widest) widest = r.consumed;
      end
      strings_seen++;
      expected_results.push_back(r);
      clear();
    endfunction

    function void check_result(logic [VAL_W-1:0] v, logic [CONS_W-1:0] cons, logic ovf,
                               logic [1:0] st);
      parse_result_t r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: value %h consumed %0d ovf %b status %0d",
                   $realtime, v, cons, ovf, st);
        return;
      end
      r = expected_results.pop_front();
      if (v !== r.value || cons !== r.consumed || ovf !== r.overflowed || st !== r.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] mismatch (exp/act): value %h/%h consumed %0d/%0d ovf %b/%b status %0d/%0d",
                   $realtime, r.value, v, r.consumed, cons, r.overflowed, ovf, r.status, st);
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  stip_in_if  in_ch ();
  stip_out_if out_ch ();
  stip_cfg_if cfg_ch ();

  string_to_integer_parser u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .cfg_ch_i (cfg_ch)
  );

  strtol_scoreboard parse_sb;
  int unsigned      burst_left;
  int unsigned      items_sent;
  int unsigned      settings_used;
  int unsigned      quiet_cycles;
  int unsigned      holds_done;
  bit               hold_req;

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: ready pattern changes every so often, plus one long hold-off on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned tick;
    out_ch.ready = 1'b0;
    mode         = RX_OPEN;
    tick         = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        holds_done++;
      end
      if (tick % 50 == 0) mode = rx_mode_e'($urandom_range(0, 3));
      tick++;
      case (mode)
        RX_OPEN:   out_ch.ready = 1'b1;
        RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready = (tick % 4 == 0);
        default:   out_ch.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      parse_sb.check_result(out_ch.value, out_ch.consumed, out_ch.overflowed, out_ch.status);
  end

  // Watchdog on cycles with no request moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Called and returns at a falling edge
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    in_ch.last_char = lst;
    do @(posedge clk); while (!in_ch.ready);
    parse_sb.note_char(c, lst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    while (parse_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [RADIX_W-1:0] radix,
                                input logic [CFG_DATA_W-1:0] sgn_data);
    in_ch.valid = 1'b0;
    drain();
    cfg_ch.valid = 1'b1;
    cfg_ch.index = CFG_RADIX;
    cfg_ch.data  = CFG_DATA_W'(radix);
    do @(posedge clk); while (!cfg_ch.ready);
    parse_sb.write_reg(CFG_RADIX, CFG_DATA_W'(radix));
    @(negedge clk);
    cfg_ch.index = CFG_SIGNED;
    cfg_ch.data  = sgn_data;
    do @(posedge clk); while (!cfg_ch.ready);
    parse_sb.write_reg(CFG_SIGNED, sgn_data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed numbers with random content; some noise and ragged tails
  task automatic send_random_string(input logic [RADIX_W-1:0] radix, input bit go_long);
    logic [CHAR_W-1:0] chars_q[$];
    int unsigned       n_ws;
    int unsigned       n_dig;
    int unsigned       eff;
    int unsigned       v;
    chars_q = {};
    if (!go_long && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) chars_q.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      if (go_long) n_ws = $urandom_range(240, 262);
      else n_ws = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n_ws) begin
        v = $urandom_range(CH_TAB - 1, CH_CR);
        chars_q.push_back((v == CH_TAB - 1) ? CH_SPACE : CHAR_W'(v));
      end
      case ($urandom_range(0, 3))
        0: chars_q.push_back(CH_MINUS);
        1: chars_q.push_back(CH_PLUS);
        default: ;
      endcase
      eff = (radix >= 2 && radix <= BASE_MAX) ? radix : BASE_DEC;
      if ((radix == BASE_AUTO || radix == BASE_HEX) && $urandom_range(0, 2) == 0) begin
        chars_q.push_back(CH_ZERO);
        if ($urandom_range(0, 1)) begin
          chars_q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          eff = BASE_HEX;
        end else if (radix == BASE_AUTO) begin
          eff = BASE_OCT;
        end
      end
      if (go_long) n_dig = $urandom_range(1, 24);
      else n_dig = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 8);
      repeat (n_dig) begin
        v = $urandom_range(0, eff - 1);
        if (v < LETTER_OFS) chars_q.push_back(CHAR_W'(CH_ZERO + v));
        else chars_q.push_back(CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - LETTER_OFS));
      end
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) chars_q.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    if (chars_q.size() == 0) chars_q.push_back(CHAR_W'($urandom_range(0, 255)));
    foreach (chars_q[i]) send_char(chars_q[i], i == chars_q.size() - 1);
  endtask

  initial begin : main
    logic [RADIX_W-1:0] radix_plan [N_PHASES];
    int unsigned        start_items;
    int unsigned        phase_target;
    parse_sb        = new();
    burst_left      = 0;
    items_sent      = 0;
    settings_used   = 0;
    holds_done      = 0;
    hold_req        = 1'b0;
    quiet_cycles    = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_RADIX;
    cfg_ch.data     = '0;
    radix_plan      = '{BASE_AUTO, BASE_DEC, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT, BASE_ONE,
                        6'd37, 6'd63, 6'd0, 6'd0, 6'd0};
    radix_plan[9]   = RADIX_W'($urandom_range(2, BASE_MAX));
    radix_plan[10]  = RADIX_W'($urandom_range(2, BASE_MAX));
    radix_plan[11]  = RADIX_W'($urandom_range(0, 63));
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed strings
    apply_settings(BASE_AUTO, 6'd1);
    send_str("0");
    send_str("0xg");
    send_str("-0x1F");
    send_char(8'hFF, 1'b1);
    apply_settings(BASE_ONE, 6'd0);
    send_str("7");
    apply_settings(BASE_DEC, 6'd1);
    send_str(" +");
    send_char(8'h00, 1'b1);
    apply_settings(BASE_MAX, 6'd0);
    send_str("-Zz");
    apply_settings(BASE_HEX, 6'd1);
    send_str("0Xff");

    start_items = items_sent;
    for (int p = 0; p < N_PHASES; p++) begin
      apply_settings(radix_plan[p], {(CFG_DATA_W-1)'($urandom_range(0, 31)), p[0]});
      if (p == 2) hold_req = 1'b1;
      phase_target = items_sent + (start_items + RANDOM_ITEMS - items_sent) / (N_PHASES - p);
      if (p == 1 || p == 4) send_random_string(radix_plan[p], 1'b1);
      while (items_sent < phase_target) send_random_string(radix_plan[p], 1'b0);
    end

    in_ch.valid = 1'b0;
    drain();
    $display("Covered %0d characters in %0d strings under %0d register settings, %0d long hold-off.",
             items_sent, parse_sb.strings_seen, settings_used, holds_done);
    $display("%0d converted (%0d saturated, widest consumed %0d), %0d no digits, %0d bad base.",
             parse_sb.n_ok, parse_sb.n_sat, parse_sb.widest, parse_sb.n_nodig,
             parse_sb.n_badbase);
    if (parse_sb.mismatches == 0 && parse_sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", parse_sb.mismatches,
               parse_sb.outstanding());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/stip_pkg.sv
hw/rtl/stip_if.sv
hw/rtl/stip_parse.sv
hw/rtl/stip_format.sv
hw/rtl/string_to_integer_parser.sv
hw/rtl/stip_checker.sv
dv/tb_string_to_integer_parser.sv
